### rtl/pdgh_pkg.sv
// ----------------------------------------------------------------------------
// Point density grid histogram package
// Shared types and constants for the density grid histogram unit.
// ----------------------------------------------------------------------------
package pdgh_pkg;

  localparam int unsigned COORD_BITS = 24;
  localparam int unsigned INDEX_BITS = 10;
  localparam int unsigned SIDE_BITS  = 6;
  localparam int unsigned CELL_W     = 7;
  localparam int unsigned CELL_SHIFT = 7;
  localparam int unsigned PADDR_W    = 4;
  localparam int unsigned PDATA_W    = 32;

  localparam logic [CELL_W-1:0] COUNT_MAX = 7'd127;

  localparam logic KIND_ADD  = 1'b0;
  localparam logic KIND_READ = 1'b1;

  localparam logic [1:0] REG_ORIGIN_X  = 2'd0;
  localparam logic [1:0] REG_ORIGIN_Y  = 2'd1;
  localparam logic [1:0] REG_GRID_SIDE = 2'd2;

  localparam logic [SIDE_BITS-1:0] GRID_SIDE_RESET = 6'd24;

  typedef struct packed {
    logic                          kind;
    logic signed [COORD_BITS-1:0]  point_x;
    logic signed [COORD_BITS-1:0]  point_y;
    logic        [INDEX_BITS-1:0]  cell_index;
  } in_req_t;

  typedef struct packed {
    logic              in_grid;
    logic [CELL_W-1:0] cell_count;
  } out_rsp_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] base_x;
    logic signed [COORD_BITS-1:0] base_y;
    logic        [SIDE_BITS-1:0]  grid_side;
  } cfg_t;

endpackage

### rtl/pdgh_mem.sv
// ----------------------------------------------------------------------------
// Cell count memory
// Single write port, single read port memory with registered read data.
// ----------------------------------------------------------------------------
module pdgh_mem #(
  parameter int unsigned DEPTH  = 1024,
  parameter int unsigned ADDR_W = 10,
  parameter int unsigned DATA_W = 7
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/pdgh_cfg.sv
// ----------------------------------------------------------------------------
// Configuration registers
// APB register file holding the grid origin and the grid side.
// ----------------------------------------------------------------------------
module pdgh_cfg (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [pdgh_pkg::PADDR_W-1:0] paddr,
  input  logic [pdgh_pkg::PDATA_W-1:0] pwdata,
  output logic [pdgh_pkg::PDATA_W-1:0] prdata,
  output logic                      pready,
  output pdgh_pkg::cfg_t            cfg_o
);
  import pdgh_pkg::*;

  cfg_t       cfg_q;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.base_x    <= '0;
      cfg_q.base_y    <= '0;
      cfg_q.grid_side <= GRID_SIDE_RESET;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_ORIGIN_X:  cfg_q.base_x    <= pwdata[COORD_BITS-1:0];
        REG_ORIGIN_Y:  cfg_q.base_y    <= pwdata[COORD_BITS-1:0];
        REG_GRID_SIDE: cfg_q.grid_side <= pwdata[SIDE_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_ORIGIN_X:  prdata = {{(PDATA_W-COORD_BITS){cfg_q.base_x[COORD_BITS-1]}},
                               cfg_q.base_x};
      REG_ORIGIN_Y:  prdata = {{(PDATA_W-COORD_BITS){cfg_q.base_y[COORD_BITS-1]}},
                               cfg_q.base_y};
      REG_GRID_SIDE: prdata = {{(PDATA_W-SIDE_BITS){1'b0}}, cfg_q.grid_side};
      default:       prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

### rtl/point_density_grid_histogram_unit.sv
// ----------------------------------------------------------------------------
// Point density grid histogram unit
// Bins fixed-point 2-D points into a square grid of saturating cell counts.
// ----------------------------------------------------------------------------
// A request on the input channel either adds a point (kind 0) or reads and
// clears one cell (kind 1). Each request gives exactly one response on the
// output channel: in_grid tells whether an added point was counted, and
// cell_count carries the count of a read cell before it was cleared.
// The grid origin and side are set through the APB port; the user must
// write them only while the unit is idle, which the block itself does not
// enforce. The counts live in one memory of MAX_SIDE*MAX_SIDE entries that
// is read once per request and written back at most once per request.
// One request is in flight at a time. It passes through a binning step
// (PH_BIN), a memory read step (PH_ADDR) and a write back step (PH_UPD),
// and a new request is taken only after the write back of the last one.
// After reset the unit sweeps all MAX_SIDE*MAX_SIDE entries (1024 by
// default) of the memory clear, one entry per cycle; in_stall_o stays high
// meanwhile. A stalled response holds in the output register, and the write
// back of the next request waits until that register is free.
module point_density_grid_histogram_unit #(
  parameter int unsigned MAX_SIDE = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  pdgh_pkg::in_req_t            in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output pdgh_pkg::out_rsp_t           out_data_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [pdgh_pkg::PADDR_W-1:0] paddr,
  input  logic [pdgh_pkg::PDATA_W-1:0] pwdata,
  output logic [pdgh_pkg::PDATA_W-1:0] prdata,
  output logic                         pready
);
  import pdgh_pkg::*;

  localparam int unsigned DEPTH   = MAX_SIDE * MAX_SIDE;
  localparam int unsigned ADDR_W  = $clog2(DEPTH);
  localparam int unsigned SIDE_W  = $clog2(MAX_SIDE + 1);
  localparam int unsigned COORD_W = $clog2(MAX_SIDE);
  localparam int unsigned CELL_C  = COORD_BITS + 1 - CELL_SHIFT;

  typedef enum logic [2:0] {
    PH_CLEAR,
    PH_IDLE,
    PH_BIN,
    PH_ADDR,
    PH_UPD
  } phase_e;

  cfg_t cfg;

  phase_e               phase_q;
  logic [ADDR_W-1:0]    clr_q;
  in_req_t              req_q;
  logic [COORD_W-1:0]   gx_q;
  logic [COORD_W-1:0]   gy_q;
  logic                 hit_q;
  logic                 oob_q;
  logic [ADDR_W-1:0]    addr_q;
  logic                 out_valid_q;
  out_rsp_t             out_data_q;

  logic                 in_acc;
  logic                 upd_done;
  logic [SIDE_W-1:0]    side;
  logic [COORD_BITS:0]  dx;
  logic [COORD_BITS:0]  dy;
  logic [CELL_C-2:0]    cx;
  logic [CELL_C-2:0]    cy;
  logic                 x_ok;
  logic                 y_ok;
  logic [ADDR_W-1:0]    pt_addr;
  logic [ADDR_W-1:0]    rd_addr;
  logic                 mem_we;
  logic [ADDR_W-1:0]    mem_waddr;
  logic [CELL_W-1:0]    mem_wdata;
  logic                 mem_re;
  logic [ADDR_W-1:0]    mem_raddr;
  logic [CELL_W-1:0]    mem_rdata;
  logic [CELL_W-1:0]    new_count;
  out_rsp_t             rsp;

  pdgh_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  pdgh_mem #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W),
    .DATA_W (CELL_W)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign in_stall_o = (phase_q != PH_IDLE);
  assign in_acc     = in_valid_i && (phase_q == PH_IDLE);
  assign upd_done   = (phase_q == PH_UPD) && (!out_valid_q || !out_stall_i);

  assign side = (32'(cfg.grid_side) > 32'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE)
                                                     : SIDE_W'(cfg.grid_side);

  assign dx = {req_q.point_x[COORD_BITS-1], req_q.point_x}
            - {cfg.base_x[COORD_BITS-1], cfg.base_x};
  assign dy = {req_q.point_y[COORD_BITS-1], req_q.point_y}
            - {cfg.base_y[COORD_BITS-1], cfg.base_y};
  assign cx = dx[COORD_BITS-1:CELL_SHIFT];
  assign cy = dy[COORD_BITS-1:CELL_SHIFT];
  assign x_ok = !dx[COORD_BITS] && (32'(cx) < 32'(side));
  assign y_ok = !dy[COORD_BITS] && (32'(cy) < 32'(side));

  assign pt_addr = ADDR_W'(32'(gy_q) * 32'(side) + 32'(gx_q));
  assign rd_addr = ADDR_W'(32'(req_q.cell_index));

  assign new_count = (mem_rdata == COUNT_MAX) ? mem_rdata : mem_rdata + 7'd1;

  always_comb begin
    mem_re    = (phase_q == PH_ADDR);
    mem_raddr = (req_q.kind == KIND_READ) ? rd_addr : pt_addr;
    if (phase_q == PH_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_q;
      mem_wdata = '0;
    end else begin
      mem_we    = upd_done && ((req_q.kind == KIND_READ) ? !oob_q : hit_q);
      mem_waddr = addr_q;
      mem_wdata = (req_q.kind == KIND_ADD) ? new_count : '0;
    end
  end

  always_comb begin
    rsp.in_grid    = (req_q.kind == KIND_ADD) && hit_q;
    rsp.cell_count = ((req_q.kind == KIND_READ) && !oob_q) ? mem_rdata : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_CLEAR;
      clr_q       <= '0;
      req_q       <= '0;
      gx_q        <= '0;
      gy_q        <= '0;
      hit_q       <= 1'b0;
      oob_q       <= 1'b0;
      addr_q      <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (phase_q)
        PH_CLEAR: begin
          clr_q <= clr_q + ADDR_W'(1);
          if (clr_q == ADDR_W'(DEPTH - 1)) begin
            phase_q <= PH_IDLE;
          end
        end
        PH_IDLE: begin
          if (in_acc) begin
            req_q   <= in_data_i;
            phase_q <= PH_BIN;
          end
        end
        PH_BIN: begin
          gx_q    <= COORD_W'(cx);
          gy_q    <= COORD_W'(cy);
          hit_q   <= x_ok && y_ok;
          oob_q   <= 32'(req_q.cell_index) >= 32'(DEPTH);
          phase_q <= PH_ADDR;
        end
        PH_ADDR: begin
          addr_q  <= mem_raddr;
          phase_q <= PH_UPD;
        end
        PH_UPD: begin
          if (upd_done) begin
            out_valid_q <= 1'b1;
            out_data_q  <= rsp;
            phase_q     <= PH_IDLE;
          end
        end
        default: phase_q <= PH_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef SYNTHESIS
  a_acc_to_bin : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> phase_q == PH_BIN)
    else $error("accepted request did not enter binning");

  a_rsp_from_upd : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(phase_q == PH_UPD))
    else $error("response loaded outside the write back step");

  a_rsp_exclusive : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.in_grid && out_data_o.cell_count != '0))
    else $error("response carries both a hit and a count");

  a_wb_gives_rsp : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we && phase_q == PH_UPD |=> out_valid_o && phase_q == PH_IDLE)
    else $error("write back without a response");
`endif

endmodule
